// ===== design/pibp_pkg.sv =====
// Shared constants and register codes for the bounded plane point test.
package pibp_pkg;

  // Default coordinate format: signed Q16.16
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Unit vectors are signed Q1.30; magnitudes fit 31 bits
  localparam int UNIT_FRAC = 30;
  localparam int UMAG_W    = 31;

  // Magnitude width inside the normalizer
  localparam int NORM_W = 62;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CENTRE_X    = 3'd0,
    REG_CENTRE_Y    = 3'd1,
    REG_CENTRE_Z    = 3'd2,
    REG_NORMAL_X    = 3'd3,
    REG_NORMAL_Y    = 3'd4,
    REG_NORMAL_Z    = 3'd5,
    REG_RECT_WIDTH  = 3'd6,
    REG_RECT_HEIGHT = 3'd7
  } cfg_reg_e;

endpackage

// ===== design/pibp_point_if.sv =====
// Stream interface for query point words.
interface pibp_point_if
  import pibp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

// ===== design/pibp_flag_if.sv =====
// Stream interface for result flag words.
interface pibp_flag_if ();
  logic valid;
  logic ready;
  logic on_plane;
  logic inside_res;

  modport source (output valid, output on_plane, output inside_res, input ready);
  modport sink   (input valid, input on_plane, input inside_res, output ready);
endinterface

// ===== design/point_in_bounded_plane_test.sv =====
// Point on bounded oriented rectangle test: basis sequencer and point pipeline.
//
//   channel   dir  handshake      payload
//   point_i   in   valid/ready    point_x, point_y, point_z (signed coords)
//   flags_o   out  valid/ready    on_plane, inside_res
//   cfg       in   cfg_we_i       cfg_index_i, cfg_data_i (write only)
//
// One point word per cycle, while the basis is valid and the output is not stalled, through a
// six-stage registered pipeline (subtract, split, multiply, combine, sum, compare).
// After reset or a normal write the basis is rebuilt by a sequencer with one shared
// 32x32 multiplier, a one-bit-per-cycle square root and divider; while it runs no
// point is taken. A stalled output holds its word; stages behind it fill their empty
// slots before the input side stops.
module point_in_bounded_plane_test
  import pibp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [((COORD_WIDTH > 31) ? COORD_WIDTH : 31)-1:0] cfg_data_i,
  pibp_point_if.sink             point_i,
  pibp_flag_if.source            flags_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int MW  = (CW + 1 > UNIT_FRAC + 1) ? CW + 1 : UNIT_FRAC + 1;
  localparam int HW  = MW - UNIT_FRAC;
  localparam int TW  = HW + UMAG_W + 1;
  localparam int SW  = TW + 3;
  localparam int EPS = ((1 << FRAC_BITS) + 50) / 100;
  localparam int NW  = NORM_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SHIFT, S_SQ, S_SQRT, S_DIV, S_STORE, S_CROSS
  } seq_state_e;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ACROSS = 2'd1,
    PH_UP     = 2'd2
  } phase_e;

  function automatic logic signed [31:0] sm_signed(input logic neg, input logic [30:0] mag);
    logic signed [31:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  logic signed [CW-1:0] centre_q [3];
  logic signed [CW-1:0] normal_q [3];
  logic [30:0]          width_q, height_q;
  logic                 normal_wr;

  assign normal_wr = cfg_we_i && (cfg_index_i == REG_NORMAL_X || cfg_index_i == REG_NORMAL_Y ||
                                  cfg_index_i == REG_NORMAL_Z);

  // store register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        centre_q[i] <= '0;
        normal_q[i] <= '0;
      end
      normal_q[2] <= CW'(1 << FRAC_BITS);
      width_q     <= '0;
      height_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CENTRE_X:    centre_q[0] <= cfg_data_i[CW-1:0];
        REG_CENTRE_Y:    centre_q[1] <= cfg_data_i[CW-1:0];
        REG_CENTRE_Z:    centre_q[2] <= cfg_data_i[CW-1:0];
        REG_NORMAL_X:    normal_q[0] <= cfg_data_i[CW-1:0];
        REG_NORMAL_Y:    normal_q[1] <= cfg_data_i[CW-1:0];
        REG_NORMAL_Z:    normal_q[2] <= cfg_data_i[CW-1:0];
        REG_RECT_WIDTH:  width_q     <= cfg_data_i[30:0];
        REG_RECT_HEIGHT: height_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // basis sequencer
  seq_state_e          state_q;
  phase_e              phase_q;
  logic [5:0]          cnt_q;
  logic [1:0]          comp_q;
  logic [NW-1:0]       m_q [3];
  logic [NW-1:0]       big_q;
  logic [63:0]         acc_q;
  logic [62:0]         sq_rem_q, sq_res_q, sq_bit_q;
  logic [31:0]         div_rem_q;
  logic [30:0]         quot_q;
  logic                qneg_q [3];
  logic [30:0]         qmag_q [3];
  logic signed [63:0]  tmp_q;
  logic signed [63:0]  c_q [3];
  logic signed [63:0]  prod_q;
  logic                bneg_q [3][3];
  logic [30:0]         bmag_q [3][3];
  logic                basis_valid_q;

  logic signed [31:0]  mul_a, mul_b;
  logic                src_neg [3];
  logic [NW-1:0]       src_mag [3];
  logic [NW-1:0]       src_big;
  logic [CW:0]         nrm_abs [3];
  logic [32:0]         div_rem2;
  logic                div_in;
  logic                div_ge;
  logic [31:0]         sq_len;

  // magnitudes of the raw normal at coordinate width plus one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_abs[i] = normal_q[i][CW-1] ? -{normal_q[i][CW-1], normal_q[i]}
                                     : {normal_q[i][CW-1], normal_q[i]};
    end
  end

  // pick the vector to normalize
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src_neg[i] = 1'b0;
      src_mag[i] = '0;
    end
    case (phase_q)
      PH_NORMAL: begin
        for (int i = 0; i < 3; i++) begin
          src_neg[i] = normal_q[i][CW-1];
          src_mag[i] = NW'(nrm_abs[i]);
        end
      end
      PH_ACROSS: begin
        src_neg[0] = !bneg_q[PH_NORMAL][1];
        src_mag[0] = NW'(bmag_q[PH_NORMAL][1]);
        src_neg[1] = bneg_q[PH_NORMAL][0];
        src_mag[1] = NW'(bmag_q[PH_NORMAL][0]);
      end
      PH_UP: begin
        for (int i = 0; i < 3; i++) begin
          src_neg[i] = c_q[i][63];
          src_mag[i] = NW'(c_q[i][63] ? -c_q[i] : c_q[i]);
        end
      end
      default: ;
    endcase
    src_big = src_mag[0];
    if (src_mag[1] > src_big) src_big = src_mag[1];
    if (src_mag[2] > src_big) src_big = src_mag[2];
  end

  // drive the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ: begin
        if (cnt_q < 6'd3) begin
          mul_a = $signed({2'b00, m_q[cnt_q[1:0]][29:0]});
          mul_b = mul_a;
        end
      end
      S_CROSS: begin
        case (cnt_q)
          6'd0: begin
            mul_a = sm_signed(bneg_q[PH_NORMAL][1], bmag_q[PH_NORMAL][1]);
            mul_b = sm_signed(bneg_q[PH_ACROSS][2], bmag_q[PH_ACROSS][2]);
          end
          6'd1: begin
            mul_a = sm_signed(bneg_q[PH_NORMAL][2], bmag_q[PH_NORMAL][2]);
            mul_b = sm_signed(bneg_q[PH_ACROSS][1], bmag_q[PH_ACROSS][1]);
          end
          6'd2: begin
            mul_a = sm_signed(bneg_q[PH_NORMAL][2], bmag_q[PH_NORMAL][2]);
            mul_b = sm_signed(bneg_q[PH_ACROSS][0], bmag_q[PH_ACROSS][0]);
          end
          6'd3: begin
            mul_a = sm_signed(bneg_q[PH_NORMAL][0], bmag_q[PH_NORMAL][0]);
            mul_b = sm_signed(bneg_q[PH_ACROSS][2], bmag_q[PH_ACROSS][2]);
          end
          6'd4: begin
            mul_a = sm_signed(bneg_q[PH_NORMAL][0], bmag_q[PH_NORMAL][0]);
            mul_b = sm_signed(bneg_q[PH_ACROSS][1], bmag_q[PH_ACROSS][1]);
          end
          6'd5: begin
            mul_a = sm_signed(bneg_q[PH_NORMAL][1], bmag_q[PH_NORMAL][1]);
            mul_b = sm_signed(bneg_q[PH_ACROSS][0], bmag_q[PH_ACROSS][0]);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // one restoring divide step
  assign sq_len   = sq_res_q[31:0];
  assign div_in   = (cnt_q == 6'd0) ? m_q[comp_q][0] : 1'b0;
  assign div_rem2 = {div_rem_q, div_in};
  assign div_ge   = div_rem2 >= {1'b0, sq_len};

  // advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_LOAD;
      phase_q       <= PH_NORMAL;
      cnt_q         <= '0;
      comp_q        <= '0;
      basis_valid_q <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          bneg_q[j][i] <= 1'b0;
          bmag_q[j][i] <= '0;
        end
      end
    end else if (normal_wr) begin
      state_q       <= S_LOAD;
      phase_q       <= PH_NORMAL;
      basis_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: ;
        S_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            m_q[i]    <= src_mag[i];
            qneg_q[i] <= src_neg[i];
            qmag_q[i] <= '0;
          end
          big_q   <= src_big;
          state_q <= (src_big == '0) ? S_STORE : S_SHIFT;
        end
        S_SHIFT: begin
          if (big_q[NW-1:30] != '0) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
            big_q <= big_q >> 1;
          end else if (!big_q[29]) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
            big_q <= big_q << 1;
          end else begin
            cnt_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd0) begin
            acc_q <= '0;
          end else if (cnt_q == 6'd3) begin
            sq_rem_q <= 63'(acc_q + prod_q);
            sq_res_q <= '0;
            sq_bit_q <= 63'(1) << 62;
            state_q  <= S_SQRT;
          end else begin
            acc_q <= acc_q + prod_q;
          end
        end
        S_SQRT: begin
          if (sq_bit_q == '0) begin
            comp_q    <= '0;
            cnt_q     <= '0;
            quot_q    <= '0;
            div_rem_q <= 32'(m_q[0][NW-1:1]);
            state_q   <= S_DIV;
          end else begin
            if (sq_rem_q >= sq_res_q + sq_bit_q) begin
              sq_rem_q <= sq_rem_q - (sq_res_q + sq_bit_q);
              sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
            end else begin
              sq_res_q <= sq_res_q >> 1;
            end
            sq_bit_q <= sq_bit_q >> 2;
          end
        end
        S_DIV: begin
          if (cnt_q == 6'd30) begin
            qmag_q[comp_q] <= {quot_q[29:0], div_ge};
            cnt_q          <= '0;
            quot_q         <= '0;
            if (comp_q == 2'd2) begin
              state_q <= S_STORE;
            end else begin
              comp_q    <= comp_q + 2'd1;
              div_rem_q <= 32'(m_q[comp_q + 2'd1][NW-1:1]);
            end
          end else begin
            div_rem_q <= div_ge ? 32'(div_rem2 - {1'b0, sq_len}) : div_rem2[31:0];
            quot_q    <= {quot_q[29:0], div_ge};
            cnt_q     <= cnt_q + 6'd1;
          end
        end
        S_STORE: begin
          for (int i = 0; i < 3; i++) begin
            bneg_q[phase_q][i] <= qneg_q[i];
            bmag_q[phase_q][i] <= qmag_q[i];
          end
          cnt_q <= '0;
          case (phase_q)
            PH_NORMAL: begin
              if (qmag_q[0] != '0 || qmag_q[1] != '0) begin
                phase_q <= PH_ACROSS;
                state_q <= S_LOAD;
              end else begin
                // degenerate direction: first tangent is the x axis
                for (int i = 0; i < 3; i++) begin
                  bneg_q[PH_ACROSS][i] <= 1'b0;
                  bmag_q[PH_ACROSS][i] <= (i == 0) ? (31'(1) << UNIT_FRAC) : '0;
                end
                state_q <= S_CROSS;
              end
            end
            PH_ACROSS: state_q <= S_CROSS;
            default: begin
              basis_valid_q <= 1'b1;
              state_q       <= S_IDLE;
            end
          endcase
        end
        S_CROSS: begin
          cnt_q <= cnt_q + 6'd1;
          case (cnt_q)
            6'd1, 6'd3, 6'd5: tmp_q <= prod_q;
            6'd2: c_q[0] <= tmp_q - prod_q;
            6'd4: c_q[1] <= tmp_q - prod_q;
            6'd6: begin
              c_q[2]  <= tmp_q - prod_q;
              phase_q <= PH_UP;
              state_q <= S_LOAD;
            end
            default: ;
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // register every product
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  // ---------------------------------------------------------------------------
  // point pipeline
  logic [5:0]            v_q;
  logic [5:0]            en;
  logic                  accept;

  logic signed [CW:0]    r_q   [3];
  logic [HW-1:0]         hi_q  [3];
  logic [29:0]           lo_q  [3];
  logic                  rneg_q[3];
  logic [HW+30:0]        hp_q  [3][3];
  logic [60:0]           lp_q  [3][3];
  logic                  tneg_q[3][3];
  logic signed [TW:0]    t_q   [3][3];
  logic signed [SW-1:0]  sum_q [3];
  logic                  on_q, ins_q;

  logic [SW-1:0]         amag [3];
  logic                  nz, on_c;

  // compute stall enables from the output back
  always_comb begin
    en[5] = !v_q[5] || flags_o.ready;
    for (int k = 4; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign point_i.ready = basis_valid_q && en[0];
  assign accept        = point_i.valid && point_i.ready;

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= accept;
      for (int k = 1; k < 6; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // final compare terms
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      amag[j] = sum_q[j][SW-1] ? SW'(-sum_q[j]) : SW'(sum_q[j]);
    end
    nz   = (bmag_q[PH_NORMAL][0] == '0) && (bmag_q[PH_NORMAL][1] == '0) &&
           (bmag_q[PH_NORMAL][2] == '0);
    on_c = amag[0] <= SW'(EPS);
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    // offset from centre
    if (en[0]) begin
      r_q[0] <= $signed({point_i.point_x[CW-1], point_i.point_x}) -
                $signed({centre_q[0][CW-1], centre_q[0]});
      r_q[1] <= $signed({point_i.point_y[CW-1], point_i.point_y}) -
                $signed({centre_q[1][CW-1], centre_q[1]});
      r_q[2] <= $signed({point_i.point_z[CW-1], point_i.point_z}) -
                $signed({centre_q[2][CW-1], centre_q[2]});
    end
    // split magnitudes at the unit point
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        logic [MW-1:0] mg;
        mg        = MW'(r_q[i][CW] ? -r_q[i] : r_q[i]);
        hi_q[i]   <= mg[MW-1:UNIT_FRAC];
        lo_q[i]   <= mg[UNIT_FRAC-1:0];
        rneg_q[i] <= r_q[i][CW];
      end
    end
    // partial products per lane
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          hp_q[j][i]   <= (HW+31)'(hi_q[i]) * (HW+31)'(bmag_q[j][i]);
          lp_q[j][i]   <= 61'(lo_q[i]) * 61'(bmag_q[j][i]);
          tneg_q[j][i] <= rneg_q[i] ^ bneg_q[j][i];
        end
      end
    end
    // combine into signed terms
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          logic [TW-1:0] tm;
          tm = TW'(hp_q[j][i]) + TW'(lp_q[j][i][60:UNIT_FRAC]);
          t_q[j][i] <= tneg_q[j][i] ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
        end
      end
    end
    // dot products
    if (en[4]) begin
      for (int j = 0; j < 3; j++) begin
        sum_q[j] <= SW'(t_q[j][0]) + SW'(t_q[j][1]) + SW'(t_q[j][2]);
      end
    end
    // flags
    if (en[5]) begin
      on_q  <= on_c;
      ins_q <= on_c && !nz && (width_q != '0) && (height_q != '0) &&
               ({amag[1], 1'b0} <= (SW+1)'(width_q)) &&
               ({amag[2], 1'b0} <= (SW+1)'(height_q));
    end
  end

  assign flags_o.valid      = v_q[5];
  assign flags_o.on_plane   = on_q;
  assign flags_o.inside_res = ins_q;

endmodule
